@@ rtl/core/npcc_pkg.sv @@
// shared types and constants for the nearest palette color lookup with cache
package npcc_pkg;

  localparam int PALETTE_DEPTH_DEF  = 256;
  localparam int CACHE_GUN_BITS_DEF = 5;

  localparam int COLOR_W = 24;
  localparam int IDX_W   = 8;
  localparam int PEN_W   = 8;
  localparam int DIST_W  = 18;
  localparam int SQ_W    = 16;
  localparam int EPOCH_W = 8;
  localparam int BPG_W   = 4;
  localparam int NC_W    = 9;

  localparam logic [DIST_W-1:0] INIT_BEST        = DIST_W'(196000);
  localparam logic [BPG_W-1:0]  BPG_RESET        = BPG_W'(5);
  localparam logic [NC_W-1:0]   NUM_COLORS_RESET = NC_W'(256);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_BITS_PER_GUN = 1'b0,
    REG_NUM_COLORS   = 1'b1
  } reg_e;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } pal_wr_t;

  typedef struct packed {
    logic               start;
    logic [COLOR_W-1:0] color;
  } srch_req_t;

  typedef struct packed {
    logic             done;
    logic [PEN_W-1:0] pen;
  } srch_rsp_t;

endpackage

@@ rtl/core/npcc_search.sv @@
// palette memory and pipelined nearest-distance scan
module npcc_search
  import npcc_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int CNT_W         = $clog2(PALETTE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pal_wr_t          wr_i,
  input  srch_req_t        req_i,
  input  logic [CNT_W-1:0] count_i,
  output srch_rsp_t        rsp_o
);

  localparam int PIDX_W = $clog2(PALETTE_DEPTH);

  logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] pal_rd_q;

  logic               busy_q;
  logic               found_q;
  logic [CNT_W-1:0]   rd_cnt_q;
  logic [CNT_W-1:0]   n_q;
  logic [COLOR_W-1:0] color_q;
  logic               p1_vld_q;
  logic [PIDX_W-1:0]  p1_idx_q;
  logic               p2_vld_q;
  logic [PIDX_W-1:0]  p2_idx_q;
  logic [SQ_W-1:0]    sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0]  best_q;
  logic [PIDX_W-1:0]  best_i_q;

  logic              rd_en;
  logic              done;
  logic [7:0]        ad_r, ad_g, ad_b;
  logic [DIST_W-1:0] sq_dist;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pal_mem[PIDX_W'(wr_i.idx)] <= wr_i.color;
    end
    pal_rd_q <= pal_mem[rd_cnt_q[PIDX_W-1:0]];
  end

  always_comb begin
    rd_en   = busy_q && !found_q && (rd_cnt_q != n_q);
    done    = busy_q && (found_q || ((rd_cnt_q == n_q) && !p1_vld_q && !p2_vld_q));
    ad_r    = (color_q[23:16] >= pal_rd_q[23:16]) ? color_q[23:16] - pal_rd_q[23:16]
                                                   : pal_rd_q[23:16] - color_q[23:16];
    ad_g    = (color_q[15:8] >= pal_rd_q[15:8]) ? color_q[15:8] - pal_rd_q[15:8]
                                                 : pal_rd_q[15:8] - color_q[15:8];
    ad_b    = (color_q[7:0] >= pal_rd_q[7:0]) ? color_q[7:0] - pal_rd_q[7:0]
                                               : pal_rd_q[7:0] - color_q[7:0];
    sq_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      found_q  <= 1'b0;
      rd_cnt_q <= '0;
      n_q      <= '0;
      color_q  <= '0;
      p1_vld_q <= 1'b0;
      p1_idx_q <= '0;
      p2_vld_q <= 1'b0;
      p2_idx_q <= '0;
      sq_r_q   <= '0;
      sq_g_q   <= '0;
      sq_b_q   <= '0;
      best_q   <= INIT_BEST;
      best_i_q <= '0;
    end else if (req_i.start && !busy_q) begin
      busy_q   <= 1'b1;
      found_q  <= 1'b0;
      rd_cnt_q <= '0;
      n_q      <= count_i;
      color_q  <= req_i.color;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      best_q   <= INIT_BEST;
      best_i_q <= '0;
    end else begin
      // issue
      p1_vld_q <= rd_en;
      p1_idx_q <= rd_cnt_q[PIDX_W-1:0];
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      // squares
      p2_vld_q <= p1_vld_q && !found_q;
      p2_idx_q <= p1_idx_q;
      sq_r_q   <= ad_r * ad_r;
      sq_g_q   <= ad_g * ad_g;
      sq_b_q   <= ad_b * ad_b;
      // compare, first strictly smaller wins
      if (p2_vld_q && !found_q && (sq_dist < best_q)) begin
        best_q   <= sq_dist;
        best_i_q <= p2_idx_q;
        if (sq_dist == '0) begin
          found_q <= 1'b1;
        end
      end
      if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign rsp_o.done = done;
  assign rsp_o.pen  = PEN_W'(best_i_q);

endmodule

@@ rtl/core/nearest_palette_color_cached.sv @@
// top level: nearest palette color lookup with an inverse colormap cache
//
// Input channel (valid/ready): one beat is either a lookup of color_i or a
// palette write of color_i into entry entry_index_i. A write gives no result
// on the output channel; a write to an entry beyond the palette is dropped.
// Output channel (valid/ready): one beat per lookup, the pen and whether it
// came from the cache. Items are processed one at a time and results leave
// in order through an output register, so a stalled receiver holds the
// result while the next item may already be accepted; the item after that
// waits until the register drains.
// A miss scans the palette from entry 0 through a 3-stage read, square
// and compare pipeline, one entry per cycle; an exact match ends it early.
// Cache entries carry an epoch tag; a palette or register write bumps the
// epoch. After reset, and whenever the epoch wraps (every 256th write), a
// clearing pass sweeps all 2^(3*CACHE_GUN_BITS) cache entries (32768 by
// default) and no beat is accepted; register writes are still taken.
module nearest_palette_color_cached
  import npcc_pkg::*;
#(
  parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF,
  parameter int CACHE_GUN_BITS = CACHE_GUN_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic [IDX_W-1:0]   entry_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PEN_W-1:0]   pen_o,
  output logic               from_cache_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CIDX_W = 3 * CACHE_GUN_BITS;
  localparam int CENT_W = 1 + EPOCH_W + PEN_W;
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int NW     = (CNT_W > NC_W) ? CNT_W : NC_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [CIDX_W-1:0]   clr_q;
  logic [EPOCH_W-1:0]  epoch_q;
  logic [CIDX_W-1:0]   cell_q;
  logic [COLOR_W-1:0]  color_q;
  logic [PEN_W-1:0]    res_pen_q;
  logic                res_hit_q;
  logic                out_valid_q;
  logic [PEN_W-1:0]    out_pen_q;
  logic                out_hit_q;
  logic [BPG_W-1:0]    bpg_q;
  logic [NC_W-1:0]     nc_q;

  logic [CENT_W-1:0]   cache_mem [2**CIDX_W];
  logic [CENT_W-1:0]   crd_q;
  logic                cwe;
  logic [CIDX_W-1:0]   cwa;
  logic [CENT_W-1:0]   cwd;

  logic                accept;
  logic                cfg_we;
  logic                pal_we;
  logic                inv;
  logic                cache_hit;
  logic [4:0]          gb;
  logic [7:0]          gmask;
  logic [7:0]          g_red, g_green, g_blue;
  logic [CIDX_W-1:0]   cell_idx;
  logic [CNT_W-1:0]    count;
  reg_e                cfg_reg;

  pal_wr_t             pal_wr;
  srch_req_t           srch_req;
  srch_rsp_t           srch_rsp;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign pen_o        = out_pen_q;
  assign from_cache_o = out_hit_q;
  assign pready       = 1'b1;
  assign cfg_reg      = reg_e'(paddr[2]);
  assign cfg_we       = psel && penable && pwrite && pready;
  assign pal_we       = accept && (operation_i == OP_WRITE) &&
                        (int'(entry_index_i) < PALETTE_DEPTH);
  assign inv          = cfg_we || pal_we;

  always_comb begin
    unique case (cfg_reg)
      REG_BITS_PER_GUN: prdata = 32'(bpg_q);
      REG_NUM_COLORS:   prdata = 32'(nc_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpg_q <= BPG_RESET;
      nc_q  <= NUM_COLORS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_BITS_PER_GUN: bpg_q <= pwdata[BPG_W-1:0];
        REG_NUM_COLORS:   nc_q  <= pwdata[NC_W-1:0];
        default:          ;
      endcase
    end
  end

  // cell index: top gun bits packed blue, green, red
  always_comb begin
    if (bpg_q < BPG_W'(4)) begin
      gb = 5'd4;
    end else if (int'(bpg_q) > CACHE_GUN_BITS) begin
      gb = 5'(CACHE_GUN_BITS);
    end else begin
      gb = 5'(bpg_q);
    end
    gmask    = 8'((9'd1 << gb) - 9'd1);
    g_red    = 8'(color_i >> (5'd24 - gb)) & gmask;
    g_green  = 8'(color_i >> (5'd16 - gb)) & gmask;
    g_blue   = 8'(color_i >> (5'd8 - gb)) & gmask;
    cell_idx = CIDX_W'((24'(g_blue) << 5'(gb << 1)) | (24'(g_green) << gb) | 24'(g_red));
    if (NW'(nc_q) > NW'(PALETTE_DEPTH)) begin
      count = CNT_W'(PALETTE_DEPTH);
    end else begin
      count = CNT_W'(nc_q);
    end
  end

  assign cache_hit = crd_q[CENT_W-1] && (crd_q[CENT_W-2 -: EPOCH_W] == epoch_q);

  assign cwe = (state_q == ST_CLEAR) || ((state_q == ST_FINISH) && !res_hit_q);
  assign cwa = (state_q == ST_CLEAR) ? clr_q : cell_q;
  assign cwd = (state_q == ST_CLEAR) ? '0 : {1'b1, epoch_q, res_pen_q};

  always_ff @(posedge clk_i) begin
    if (cwe) begin
      cache_mem[cwa] <= cwd;
    end
    crd_q <= cache_mem[cell_idx];
  end

  assign pal_wr.en       = pal_we;
  assign pal_wr.idx      = entry_index_i;
  assign pal_wr.color    = color_i;
  assign srch_req.start  = (state_q == ST_CHECK) && !cache_hit;
  assign srch_req.color  = color_q;

  npcc_search #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .CNT_W        (CNT_W)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (pal_wr),
    .req_i  (srch_req),
    .count_i(count),
    .rsp_o  (srch_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      epoch_q     <= '0;
      cell_q      <= '0;
      color_q     <= '0;
      res_pen_q   <= '0;
      res_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_pen_q   <= '0;
      out_hit_q   <= 1'b0;
    end else begin
      if ((state_q == ST_FINISH) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (inv) begin
        epoch_q <= epoch_q + 1'b1;
      end
      // invalidate by epoch, sweep when it wraps
      if (inv && (&epoch_q)) begin
        state_q <= ST_CLEAR;
        clr_q   <= '0;
      end else begin
        unique case (state_q)
          ST_CLEAR: begin
            clr_q <= clr_q + 1'b1;
            if (&clr_q) begin
              state_q <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (accept && (operation_i == OP_LOOKUP)) begin
              cell_q  <= cell_idx;
              color_q <= color_i;
              state_q <= ST_CHECK;
            end
          end
          ST_CHECK: begin
            if (cache_hit) begin
              res_pen_q <= crd_q[PEN_W-1:0];
              res_hit_q <= 1'b1;
              state_q   <= ST_FINISH;
            end else begin
              res_hit_q <= 1'b0;
              state_q   <= ST_SEARCH;
            end
          end
          ST_SEARCH: begin
            if (srch_rsp.done) begin
              res_pen_q <= srch_rsp.pen;
              state_q   <= ST_FINISH;
            end
          end
          ST_FINISH: begin
            if (!out_valid_q || out_ready_i) begin
              out_pen_q <= res_pen_q;
              out_hit_q <= res_hit_q;
              state_q   <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

endmodule
